// ===== hw/rtl/scp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and character codes for the Set-Cookie attribute parser.
package scp_pkg;

   // Longest header text accepted before the too-long status is reported.
   localparam int MAX_LEN = 4096;
   // Byte position counts up to MAX_LEN + 1 (saturating marker for too long).
   localparam int POS_W   = $clog2(MAX_LEN + 2);
   localparam int OFS_W   = 12;
   localparam int LEN_W   = 13;
   localparam int MASK_W  = 6;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 136;

   // Characters with a meaning to the parser.
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;

   // Bits of the present mask.
   localparam int FB_NAME     = 0;
   localparam int FB_PATH     = 1;
   localparam int FB_DOMAIN   = 2;
   localparam int FB_EXPIRY   = 3;
   localparam int FB_HTTPONLY = 4;
   localparam int FB_SECURE   = 5;

   typedef enum logic [1:0] {
      ST_PARSED   = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_TOO_LONG = 2'd2
   } scp_status_type;

   typedef enum logic [1:0] {
      PH_LEAD  = 2'd0,
      PH_KEY   = 2'd1,
      PH_VLEAD = 2'd2,
      PH_VAL   = 2'd3
   } scp_phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } scp_item_type;

   typedef struct packed {
      scp_phase_type    phase;
      logic [POS_W-1:0] key_begin;
      logic [POS_W-1:0] key_trim_end;
      logic [POS_W-1:0] val_begin;
      logic [POS_W-1:0] val_trim_end;
      logic [4:0]       kw_match;
      logic             key_blank;
   } scp_seg_type;

   localparam scp_seg_type SEG_CLEAR = '{
      phase:        PH_LEAD,
      key_begin:    '0,
      key_trim_end: '0,
      val_begin:    '0,
      val_trim_end: '0,
      kw_match:     5'h1F,
      key_blank:    1'b0
   };

   typedef struct packed {
      logic [OFS_W-1:0] start;
      logic [LEN_W-1:0] len;
   } scp_span_type;

   typedef struct packed {
      scp_span_type      name;
      scp_span_type      value;
      scp_span_type      path;
      scp_span_type      domain;
      scp_span_type      expiry;
      logic [MASK_W-1:0] found;
   } scp_cap_type;

   typedef struct packed {
      scp_span_type      name;
      scp_span_type      value;
      scp_span_type      path;
      scp_span_type      domain;
      scp_span_type      expiry;
      logic [MASK_W-1:0] present_mask;
      scp_status_type    status;
   } scp_result_type;

endpackage

// ===== hw/rtl/set_cookie_attribute_parser.sv =====
`timescale 1ns / 1ps
// Top level of the Set-Cookie attribute parser.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------------------
//  req_     | in        | tdata[7:0] header byte, tlast marks the final byte of a header
//  rsp_     | out       | tdata: name, value, path, domain, expiry spans, mask, status
//
// One header byte is taken per cycle while no waiting result stalls the input; each byte passes
// through the input register. The result register loads when the final byte (or the first NUL)
// leaves that register, and rsp_tvalid rises with that load.
// Reset (synchronous) clears both valid flags and the parser state; no clearing pass.
// While a result waits on rsp_tready, the input register holds one more byte and
// req_tready drops only once that register is also occupied.
module set_cookie_attribute_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [7:0] in_byte
   input  logic [scp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [11:0] name_start, [24:12] name_len, [36:25] value_start, [49:37] value_len,
   // [61:50] path_start, [74:62] path_len, [86:75] domain_start, [99:87] domain_len,
   // [111:100] expiry_start, [124:112] expiry_len, [130:125] present_mask,
   // [132:131] status, [135:133] zero
   output logic [scp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import scp_pkg::*;

   logic           item_valid;
   scp_item_type   item;
   logic           advance;
   logic           out_free;
   logic           result_valid;
   scp_result_type result;
   scp_result_type rsp_result;

   // Advance the held byte whenever the result register can take what it produces.
   assign advance = item_valid && out_free;

   scp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   scp_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .take         (advance),
      .item         (item),
      .result_valid (result_valid),
      .result       (result)
   );

   scp_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .take         (advance),
      .result_valid (result_valid),
      .result       (result),
      .free         (out_free),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_result   (rsp_result)
   );

   // Pack the result, first field in the lowest bits, zero fill to a whole byte.
   assign rsp_tdata = {3'b000,
                       rsp_result.status,
                       rsp_result.present_mask,
                       rsp_result.expiry.len, rsp_result.expiry.start,
                       rsp_result.domain.len, rsp_result.domain.start,
                       rsp_result.path.len,   rsp_result.path.start,
                       rsp_result.value.len,  rsp_result.value.start,
                       rsp_result.name.len,   rsp_result.name.start};

endmodule

// ===== hw/rtl/scp_in_reg.sv =====
`timescale 1ns / 1ps
// Input register stage: holds one accepted header byte until the parser takes it.
module scp_in_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [scp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           take,
   output logic                           item_valid,
   output scp_pkg::scp_item_type          item
);
   import scp_pkg::*;

   logic         valid_ff, valid_in;
   scp_item_type item_ff, item_in;
   logic         accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in        = 1'b1;
         item_in.in_byte = req_tdata[7:0];
         item_in.is_last = req_tlast;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hw/rtl/scp_parse.sv =====
`timescale 1ns / 1ps
// Parser core: segment tracking, keyword match, capture and result formation.
module scp_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  scp_pkg::scp_item_type   item,
   output logic                    result_valid,
   output scp_pkg::scp_result_type result
);
   import scp_pkg::*;

   localparam int         KW_N        = 5;
   localparam logic [2:0] KW_PATH     = 3'd0;
   localparam logic [2:0] KW_DOMAIN   = 3'd1;
   localparam logic [2:0] KW_EXPIRES  = 3'd2;
   localparam logic [2:0] KW_HTTPONLY = 3'd3;
   localparam logic [2:0] KW_SECURE   = 3'd4;
   localparam logic [KW_N-1:0] KW_ALL = 5'h1F;

   function automatic logic [3:0] kw_len(input logic [2:0] k);
      logic [3:0] n;
      case (k)
         KW_PATH:     n = 4'd4;
         KW_DOMAIN:   n = 4'd6;
         KW_EXPIRES:  n = 4'd7;
         KW_HTTPONLY: n = 4'd8;
         KW_SECURE:   n = 4'd6;
         default:     n = 4'd0;
      endcase
      return n;
   endfunction

   // Keyword text, left aligned, lower case.
   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
      logic [63:0] w;
      case (k)
         KW_PATH:     w = {"path", 32'h0};
         KW_DOMAIN:   w = {"domain", 16'h0};
         KW_EXPIRES:  w = {"expires", 8'h0};
         KW_HTTPONLY: w = "httponly";
         KW_SECURE:   w = {"secure", 16'h0};
         default:     w = '0;
      endcase
      return w[8 * (7 - int'(i)) +: 8];
   endfunction

   function automatic logic [KW_N-1:0] match_char(input logic [KW_N-1:0] mask,
                                                   input logic [POS_W-1:0] idx,
                                                   input logic [7:0] c);
      logic [KW_N-1:0] r;
      logic [7:0]      lc;
      lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
      for (int k = 0; k < KW_N; k++) begin
         r[k] = mask[k] && (idx < POS_W'(kw_len(3'(k))))
                && (lc == kw_char(3'(k), idx[2:0]));
      end
      return r;
   endfunction

   function automatic logic kw_hit(input scp_seg_type seg, input logic [LEN_W-1:0] klen,
                                   input logic [2:0] k);
      return seg.kw_match[k] && (klen == LEN_W'(kw_len(k)));
   endfunction

   // Close the open segment and fold it into the captured fields.
   function automatic scp_cap_type close_seg(input scp_seg_type seg, input scp_cap_type cap,
                                             input logic at_end,
                                             input logic [POS_W-1:0] endpos);
      scp_cap_type      r;
      logic [LEN_W-1:0] klen;
      logic [POS_W-1:0] vstart;
      logic [LEN_W-1:0] vlen;
      r      = cap;
      klen   = LEN_W'(seg.key_trim_end - seg.key_begin);
      vstart = seg.val_begin;
      vlen   = '0;
      unique case (seg.phase) inside
         PH_LEAD: begin
         end
         PH_KEY: begin
            if (!at_end || !seg.key_blank) begin
               if (kw_hit(seg, klen, KW_HTTPONLY)) begin
                  r.found[FB_HTTPONLY] = 1'b1;
               end else if (kw_hit(seg, klen, KW_SECURE)) begin
                  r.found[FB_SECURE] = 1'b1;
               end
            end
         end
         PH_VLEAD, PH_VAL: begin
            if (seg.phase == PH_VLEAD) begin
               vstart = at_end ? endpos : seg.val_begin;
            end else begin
               vlen = LEN_W'((at_end ? endpos : seg.val_trim_end) - seg.val_begin);
            end
            if (!r.found[FB_NAME]) begin
               r.name.start        = OFS_W'(seg.key_begin);
               r.name.len          = klen;
               r.value.start       = OFS_W'(vstart);
               r.value.len         = vlen;
               r.found[FB_NAME]    = 1'b1;
            end else if (kw_hit(seg, klen, KW_PATH)) begin
               r.path.start        = OFS_W'(vstart);
               r.path.len          = vlen;
               r.found[FB_PATH]    = 1'b1;
            end else if (kw_hit(seg, klen, KW_DOMAIN)) begin
               r.domain.start      = OFS_W'(vstart);
               r.domain.len        = vlen;
               r.found[FB_DOMAIN]  = 1'b1;
            end else if (kw_hit(seg, klen, KW_EXPIRES)) begin
               r.expiry.start      = OFS_W'(vstart);
               r.expiry.len        = vlen;
               r.found[FB_EXPIRY]  = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   logic [POS_W-1:0] pos_ff, pos_in;
   scp_seg_type      seg_ff, seg_in;
   scp_cap_type      cap_ff, cap_in;
   logic             ended_ff, ended_in;

   logic [POS_W-1:0] mid_pos;
   scp_seg_type      mid_seg;
   scp_cap_type      mid_cap;
   logic             blank;
   logic             is_nul;

   logic [POS_W-1:0] src_pos;
   scp_seg_type      src_seg;
   scp_cap_type      src_cap;
   scp_cap_type      fin_cap;

   assign blank  = (item.in_byte == CH_SPACE) || (item.in_byte == CH_TAB);
   assign is_nul = (item.in_byte == CH_NUL);

   // Apply one text byte to the segment tracker.
   always_comb begin
      mid_pos = pos_ff;
      mid_seg = seg_ff;
      mid_cap = cap_ff;
      if (pos_ff < POS_W'(MAX_LEN)) begin
         mid_pos = pos_ff + 1'b1;
         if (item.in_byte == CH_SEMI) begin
            mid_cap = close_seg(seg_ff, cap_ff, 1'b0, pos_ff);
            mid_seg = SEG_CLEAR;
         end else begin
            unique case (seg_ff.phase)
               PH_LEAD: begin
                  if (!blank) begin
                     mid_seg.key_begin = pos_ff;
                     if (item.in_byte == CH_EQUAL) begin
                        mid_seg.key_trim_end = pos_ff;
                        mid_seg.val_begin    = pos_ff + 1'b1;
                        mid_seg.val_trim_end = pos_ff + 1'b1;
                        mid_seg.phase        = PH_VLEAD;
                     end else begin
                        mid_seg.key_trim_end = pos_ff + 1'b1;
                        mid_seg.key_blank    = 1'b0;
                        mid_seg.kw_match     = match_char(KW_ALL, '0, item.in_byte);
                        mid_seg.phase        = PH_KEY;
                     end
                  end
               end
               PH_KEY: begin
                  if (blank) begin
                     mid_seg.key_blank = 1'b1;
                  end else if (item.in_byte == CH_EQUAL) begin
                     mid_seg.val_begin    = pos_ff + 1'b1;
                     mid_seg.val_trim_end = pos_ff + 1'b1;
                     mid_seg.phase        = PH_VLEAD;
                  end else begin
                     // A blank inside the key kills every keyword candidate.
                     mid_seg.kw_match     = seg_ff.key_blank ? '0 :
                        match_char(seg_ff.kw_match, pos_ff - seg_ff.key_begin, item.in_byte);
                     mid_seg.key_blank    = 1'b0;
                     mid_seg.key_trim_end = pos_ff + 1'b1;
                  end
               end
               PH_VLEAD: begin
                  if (!blank) begin
                     mid_seg.val_begin    = pos_ff;
                     mid_seg.val_trim_end = pos_ff + 1'b1;
                     mid_seg.phase        = PH_VAL;
                  end
               end
               PH_VAL: begin
                  if (!blank) begin
                     mid_seg.val_trim_end = pos_ff + 1'b1;
                  end
               end
            endcase
         end
      end else begin
         mid_pos = POS_W'(MAX_LEN + 1);
      end
   end

   // Next state.
   always_comb begin
      pos_in   = pos_ff;
      seg_in   = seg_ff;
      cap_in   = cap_ff;
      ended_in = ended_ff;
      if (take) begin
         if (ended_ff || is_nul || item.is_last) begin
            // Drop bytes after a NUL until the last one; otherwise restart after a result.
            if (!ended_ff || item.is_last) begin
               pos_in   = '0;
               seg_in   = SEG_CLEAR;
               cap_in   = '0;
               ended_in = !ended_ff && is_nul && !item.is_last;
            end
         end else begin
            pos_in = mid_pos;
            seg_in = mid_seg;
            cap_in = mid_cap;
         end
      end
   end

   // Result formation.
   always_comb begin
      result_valid = !ended_ff && (is_nul || item.is_last);
      src_pos      = is_nul ? pos_ff : mid_pos;
      src_seg      = is_nul ? seg_ff : mid_seg;
      src_cap      = is_nul ? cap_ff : mid_cap;
      fin_cap      = close_seg(src_seg, src_cap, 1'b1, src_pos);
      result       = '0;
      if (src_pos == '0) begin
         result.status = ST_EMPTY;
      end else if (src_pos > POS_W'(MAX_LEN)) begin
         result.status = ST_TOO_LONG;
      end else begin
         result.name         = fin_cap.name;
         result.value        = fin_cap.value;
         result.path         = fin_cap.path;
         result.domain       = fin_cap.domain;
         result.expiry       = fin_cap.expiry;
         result.present_mask = fin_cap.found;
         result.status       = ST_PARSED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         seg_ff   <= SEG_CLEAR;
         cap_ff   <= '0;
         ended_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         seg_ff   <= seg_in;
         cap_ff   <= cap_in;
         ended_ff <= ended_in;
      end
   end

endmodule

// ===== hw/rtl/scp_out_reg.sv =====
`timescale 1ns / 1ps
// Result register: holds one parse result until the downstream side takes it.
module scp_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic                    result_valid,
   input  scp_pkg::scp_result_type result,
   output logic                    free,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output scp_pkg::scp_result_type rsp_result
);
   import scp_pkg::*;

   logic           valid_ff, valid_in;
   scp_result_type data_ff, data_in;
   logic           load;

   assign free = !valid_ff || rsp_tready;
   assign load = take && result_valid;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = data_ff;

endmodule

// ===== hw/rtl/scp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the Set-Cookie attribute parser, bound to the top level.
module scp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [scp_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [scp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import scp_pkg::*;

   logic [1:0] status;
   logic [5:0] mask;

   assign status = rsp_tdata[132:131];
   assign mask   = rsp_tdata[130:125];

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Input side only backs up when the result side is stalled.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // Empty or too-long text carries no spans and no mask.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status != ST_PARSED) |-> rsp_tdata[130:0] == '0)
      else $error("error result carries payload");

   // Without a name, the name, value and path slots read as zero and no path is flagged.
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !mask[FB_NAME] |-> rsp_tdata[49:0] == '0 && !mask[FB_PATH]
         && rsp_tdata[74:50] == '0)
      else $error("absent slot not zero");

   a_no_bad_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> status != 2'd3 && rsp_tdata[135:133] == '0)
      else $error("bad status or fill bits");

   logic unused_in;
   assign unused_in = ^{req_tvalid, req_tdata, req_tlast};

endmodule

bind set_cookie_attribute_parser scp_checker u_scp_checker (.*);
